// File: hw/rtl/cte_pkg.sv
package cte_pkg;

    localparam int YEARS_W = 10;
    localparam int MONTH_W = 11;
    localparam int MDAY_W  = 5;
    localparam int YDAY_W  = 9;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int EPOCH_W = 36;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    // internal widths
    localparam int YEAR_W  = 12;   // folded year, 1814..3008
    localparam int MON_W   = 4;    // folded month, 0..11
    localparam int Q12_W   = 7;    // year shift from month folding, up to 86
    localparam int Q100_W  = 5;    // year / 100, up to 30
    localparam int HMS_W   = 17;   // seconds within a day, unchecked, up to 115443
    localparam int DIY_W   = 9;    // day within year, up to 511
    localparam int DB_W    = 21;   // days before year, counted from year 1
    localparam int DAYS_W  = 20;   // signed days since epoch
    localparam int SPD_W   = 18;   // signed width holding seconds per day
    localparam int CUM_W   = 9;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [YEAR_W-1:0] BASE_YEAR = 12'd1900;
    localparam int MONTH_LAST = 11;

    // floor(u / 12) = (u * 2731) >> 15 for u < 2048
    localparam int RECIP12       = 2731;
    localparam int RECIP12_W     = 12;
    localparam int RECIP12_SHIFT = 15;

    // floor(y / 100) = (y * 5243) >> 19 for y < 4096
    localparam int RECIP100       = 5243;
    localparam int RECIP100_W     = 13;
    localparam int RECIP100_SHIFT = 19;

    localparam int DAYS_BEFORE_EPOCH = 719162;
    localparam int SECS_PER_DAY      = 86400;
    localparam int SECS_PER_HOUR     = 3600;
    localparam int SECS_PER_MIN      = 60;

    typedef enum logic [1:0] {
        FOLD_NONE,
        FOLD_UP,
        FOLD_DOWN
    } fold_t;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [MDAY_W-1:0] mday;
        logic [YDAY_W-1:0] yday;
        logic [HMS_W-1:0]  hms;
    } date_t;

    function automatic logic [CUM_W-1:0] cum_days(input logic leap,
                                                   input logic [MON_W-1:0] month);
        logic [CUM_W-1:0] base;
        logic [CUM_W-1:0] extra;
        unique case (month)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        extra = (leap && (month >= 4'd2)) ? 9'd1 : 9'd0;
        return base + extra;
    endfunction

endpackage

// File: hw/rtl/cte_front.sv
module cte_front import cte_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [YEARS_W-1:0]        years_since_1900,
    input  logic signed [MONTH_W-1:0] month_index,
    input  logic [MDAY_W-1:0]         day_of_month,
    input  logic [YDAY_W-1:0]         year_day,
    input  logic [HOUR_W-1:0]         hour_of_day,
    input  logic [MIN_W-1:0]          minute_of_hour,
    input  logic [SEC_W-1:0]          second_of_minute,
    output logic                      out_valid,
    input  logic                      out_ready,
    output date_t                     out_data
);

    localparam logic signed [MONTH_W:0] MONTH_MAX = (MONTH_W+1)'(MONTH_LAST);
    localparam int PROD12_W = MONTH_W + RECIP12_W;

    // stage 0: classify month, seconds of day
    logic                v0_reg, v0_next;
    fold_t               kind0_reg, kind0_next;
    logic [MONTH_W-1:0]  u0_reg, u0_next;
    logic [YEARS_W-1:0]  y0_reg;
    logic [MONTH_W-1:0]  m0_reg;
    logic [MDAY_W-1:0]   mday0_reg;
    logic [YDAY_W-1:0]   yday0_reg;
    logic [HMS_W-1:0]    hms0_reg, hms0_next;

    // stage 1: year shift
    logic                v1_reg, v1_next;
    fold_t               kind1_reg;
    logic [Q12_W-1:0]    q1_reg, q1_next;
    logic [YEARS_W-1:0]  y1_reg;
    logic [MONTH_W-1:0]  m1_reg;
    logic [MDAY_W-1:0]   mday1_reg;
    logic [YDAY_W-1:0]   yday1_reg;
    logic [HMS_W-1:0]    hms1_reg;

    logic                ready0, ready1;
    logic signed [MONTH_W:0] month_ext;
    logic signed [MONTH_W:0] down_span;
    logic [PROD12_W-1:0] prod12;
    logic [MONTH_W-1:0]  q_times12;

    assign ready1   = !v1_reg || out_ready;
    assign ready0   = !v0_reg || ready1;
    assign in_ready = ready0;

    assign month_ext = {month_index[MONTH_W-1], month_index};
    assign down_span = MONTH_MAX - month_ext;

    always_comb begin
        if (!month_index[MONTH_W-1] &&
            (month_index[MONTH_W-2:0] > (MONTH_W-1)'(MONTH_LAST))) begin
            kind0_next = FOLD_UP;
            u0_next    = month_index;
        end else if (month_index[MONTH_W-1]) begin
            kind0_next = FOLD_DOWN;
            u0_next    = down_span[MONTH_W-1:0];
        end else begin
            kind0_next = FOLD_NONE;
            u0_next    = '0;
        end
        hms0_next = HMS_W'(32'(hour_of_day) * SECS_PER_HOUR
                         + 32'(minute_of_hour) * SECS_PER_MIN
                         + 32'(second_of_minute));
    end

    assign prod12  = PROD12_W'(u0_reg) * PROD12_W'(RECIP12);
    assign q1_next = prod12[RECIP12_SHIFT +: Q12_W];

    always_comb begin
        v0_next = ready0 ? in_valid : v0_reg;
        v1_next = ready1 ? v0_reg : v1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready0 && in_valid) begin
            kind0_reg <= kind0_next;
            u0_reg    <= u0_next;
            y0_reg    <= years_since_1900;
            m0_reg    <= month_index;
            mday0_reg <= day_of_month;
            yday0_reg <= year_day;
            hms0_reg  <= hms0_next;
        end
        if (ready1 && v0_reg) begin
            kind1_reg <= kind0_reg;
            q1_reg    <= q1_next;
            y1_reg    <= y0_reg;
            m1_reg    <= m0_reg;
            mday1_reg <= mday0_reg;
            yday1_reg <= yday0_reg;
            hms1_reg  <= hms0_reg;
        end
    end

    assign q_times12 = MONTH_W'(q1_reg) * MONTH_W'(12);

    always_comb begin
        out_data.mday = mday1_reg;
        out_data.yday = yday1_reg;
        out_data.hms  = hms1_reg;
        unique case (kind1_reg)
            FOLD_UP: begin
                out_data.year  = BASE_YEAR + YEAR_W'(y1_reg) + YEAR_W'(q1_reg);
                out_data.month = MON_W'(m1_reg - q_times12);
            end
            FOLD_DOWN: begin
                out_data.year  = BASE_YEAR + YEAR_W'(y1_reg) - YEAR_W'(q1_reg);
                out_data.month = MON_W'(m1_reg + q_times12);
            end
            default: begin
                out_data.year  = BASE_YEAR + YEAR_W'(y1_reg);
                out_data.month = m1_reg[MON_W-1:0];
            end
        endcase
    end

    assign out_valid = v1_reg;

endmodule

// File: hw/rtl/cte_queue.sv
module cte_queue import cte_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  date_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output date_t out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    date_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count missed a push");

    a_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("queue count missed a pop");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue empty with pointers apart");

endmodule

// File: hw/rtl/cte_back.sv
module cte_back import cte_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  date_t                     in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [EPOCH_W-1:0] epoch_seconds
);

    localparam int PROD100_W = YEAR_W + RECIP100_W;
    localparam logic signed [SPD_W-1:0] SPD_S = SPD_W'(SECS_PER_DAY);

    logic ready0, ready1, ready2, ready3, ready4;

    // stage 0: year / 100 and (year - 1) / 100
    logic               v0_reg, v0_next;
    date_t              d0_reg;
    logic [YEAR_W-1:0]  p0_reg, p0_next;
    logic [Q100_W-1:0]  qy0_reg, qy0_next;
    logic [Q100_W-1:0]  qp0_reg, qp0_next;
    logic [PROD100_W-1:0] prod_y, prod_p;

    // stage 1: leap rule, days before year, day within year
    logic               v1_reg, v1_next;
    logic [DB_W-1:0]    db1_reg, db1_next;
    logic [DIY_W-1:0]   diy1_reg, diy1_next;
    logic [HMS_W-1:0]   hms1_reg;
    logic [YEAR_W-1:0]  hundreds;
    logic               leap;

    // stage 2: days since epoch
    logic               v2_reg, v2_next;
    logic signed [DAYS_W-1:0] days2_reg, days2_next;
    logic [HMS_W-1:0]   hms2_reg;
    logic signed [DB_W:0] days_wide;

    // stage 3: days scaled to seconds
    logic               v3_reg, v3_next;
    logic signed [EPOCH_W-1:0] prod3_reg, prod3_next;
    logic signed [DAYS_W+SPD_W-1:0] prod_days;
    logic [HMS_W-1:0]   hms3_reg;

    // stage 4: seconds of day added, output register
    logic               v4_reg, v4_next;
    logic signed [EPOCH_W-1:0] epoch4_reg, epoch4_next;

    assign ready4   = !v4_reg || out_ready;
    assign ready3   = !v3_reg || ready4;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign ready0   = !v0_reg || ready1;
    assign in_ready = ready0;

    always_comb begin
        v0_next = ready0 ? in_valid : v0_reg;
        v1_next = ready1 ? v0_reg : v1_reg;
        v2_next = ready2 ? v1_reg : v2_reg;
        v3_next = ready3 ? v2_reg : v3_reg;
        v4_next = ready4 ? v3_reg : v4_reg;
    end

    assign p0_next  = in_data.year - YEAR_W'(1);
    assign prod_y   = PROD100_W'(in_data.year) * PROD100_W'(RECIP100);
    assign prod_p   = PROD100_W'(p0_next) * PROD100_W'(RECIP100);
    assign qy0_next = prod_y[RECIP100_SHIFT +: Q100_W];
    assign qp0_next = prod_p[RECIP100_SHIFT +: Q100_W];

    assign hundreds = YEAR_W'(qy0_reg) * YEAR_W'(100);

    always_comb begin
        if (d0_reg.year == hundreds) begin
            leap = (qy0_reg[1:0] == 2'd0);
        end else begin
            leap = (d0_reg.year[1:0] == 2'd0);
        end
        db1_next = DB_W'(p0_reg) * DB_W'(365)
                 + DB_W'(qp0_reg >> 2)
                 - DB_W'(qp0_reg)
                 + DB_W'(p0_reg >> 2);
        if (d0_reg.mday != '0) begin
            diy1_next = DIY_W'(cum_days(leap, d0_reg.month))
                      + DIY_W'(d0_reg.mday) - DIY_W'(1);
        end else begin
            diy1_next = d0_reg.yday;
        end
    end

    assign days_wide = $signed({1'b0, db1_reg})
                     - $signed((DB_W+1)'(DAYS_BEFORE_EPOCH))
                     + $signed({{(DB_W+1-DIY_W){1'b0}}, diy1_reg});
    assign days2_next = days_wide[DAYS_W-1:0];

    assign prod_days  = days2_reg * SPD_S;
    assign prod3_next = prod_days[EPOCH_W-1:0];

    assign epoch4_next = prod3_reg + $signed({{(EPOCH_W-HMS_W){1'b0}}, hms3_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready0 && in_valid) begin
            d0_reg  <= in_data;
            p0_reg  <= p0_next;
            qy0_reg <= qy0_next;
            qp0_reg <= qp0_next;
        end
        if (ready1 && v0_reg) begin
            db1_reg  <= db1_next;
            diy1_reg <= diy1_next;
            hms1_reg <= d0_reg.hms;
        end
        if (ready2 && v1_reg) begin
            days2_reg <= days2_next;
            hms2_reg  <= hms1_reg;
        end
        if (ready3 && v2_reg) begin
            prod3_reg <= prod3_next;
            hms3_reg  <= hms2_reg;
        end
        if (ready4 && v3_reg) begin
            epoch4_reg <= epoch4_next;
        end
    end

    assign out_valid     = v4_reg;
    assign epoch_seconds = epoch4_reg;

endmodule

// File: hw/rtl/calendar_to_epoch_seconds.sv
// channel  dir  width  fields (low bit up)
// s_       in   56     years_since_1900[9:0], month_index[20:10], day_of_month[25:21],
//                      year_day[34:26], hour_of_day[39:35], minute_of_hour[45:40],
//                      second_of_minute[51:46], zero[55:52]
// m_       out  40     epoch_seconds[35:0] signed, zero[39:36]
//
// One transaction per cycle sustained while m_tready stays high and QUEUE_DEPTH exceeds 1.
// The path runs through the front (month fold, 2 stages), the queue (1) and the back
// (leap rule, day count, days times 86400, seconds add: 5 stages).
// aresetn clears all valid flags and queue pointers; no data is held over.
// A stalled m_ side fills the back, then the queue, then the front before s_tready drops.
module calendar_to_epoch_seconds import cte_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // years, month, mday, yday, hour, min, sec
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // epoch_seconds
);

    localparam int OFS_MONTH = YEARS_W;
    localparam int OFS_MDAY  = OFS_MONTH + MONTH_W;
    localparam int OFS_YDAY  = OFS_MDAY + MDAY_W;
    localparam int OFS_HOUR  = OFS_YDAY + YDAY_W;
    localparam int OFS_MIN   = OFS_HOUR + HOUR_W;
    localparam int OFS_SEC   = OFS_MIN + MIN_W;

    logic  fq_valid, fq_ready;
    date_t fq_data;
    logic  qb_valid, qb_ready;
    date_t qb_data;
    logic signed [EPOCH_W-1:0] epoch_seconds;

    cte_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .years_since_1900 (s_tdata[YEARS_W-1:0]),
        .month_index      ($signed(s_tdata[OFS_MONTH +: MONTH_W])),
        .day_of_month     (s_tdata[OFS_MDAY +: MDAY_W]),
        .year_day         (s_tdata[OFS_YDAY +: YDAY_W]),
        .hour_of_day      (s_tdata[OFS_HOUR +: HOUR_W]),
        .minute_of_hour   (s_tdata[OFS_MIN +: MIN_W]),
        .second_of_minute (s_tdata[OFS_SEC +: SEC_W]),
        .out_valid        (fq_valid),
        .out_ready        (fq_ready),
        .out_data         (fq_data)
    );

    cte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    cte_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (qb_valid),
        .in_ready      (qb_ready),
        .in_data       (qb_data),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .epoch_seconds (epoch_seconds)
    );

    assign m_tdata = {{(M_TDATA_W-EPOCH_W){1'b0}}, epoch_seconds};

endmodule

// File: bench/tb_calendar_to_epoch_seconds.sv
`timescale 1ns / 1ps

module tb_calendar_to_epoch_seconds;
    import cte_pkg::*;

    localparam int PIPE_LAT = 10;

    // fields from the lowest bit up: years, month, mday, yday, hour, minute, second, pad
    typedef struct packed {
        logic [3:0]         pad;
        logic [SEC_W-1:0]   sec;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [YDAY_W-1:0]  yday;
        logic [MDAY_W-1:0]  mday;
        logic [MONTH_W-1:0] month;
        logic [YEARS_W-1:0] years;
    } stamp_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [EPOCH_W-1:0] expected_epochs[$];
    int  mismatch_cnt = 0;
    bit  src_idle_en  = 1'b0;
    bit  sink_stall_en = 1'b0;
    int  sink_hold_req = 0;

    calendar_to_epoch_seconds u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #200000;
        $display("Mismatches found");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic longint days_to_jan1(longint yr);
        longint p;
        p = yr - 1;
        return 365 * p + p / 400 - p / 100 + p / 4;
    endfunction

    function automatic logic [EPOCH_W-1:0] epoch_of(stamp_t t);
        int     month_start[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
        longint yr;
        longint mon;
        longint back;
        longint diy;
        longint days;
        longint total;
        bit     leap;
        yr  = longint'(t.years) + 1900;
        mon = longint'($signed(t.month));
        if (mon > 11) begin
            yr  = yr + mon / 12;
            mon = mon % 12;
        end else if (mon < 0) begin
            back = (11 - mon) / 12;
            yr   = yr - back;
            mon  = mon + 12 * back;
        end
        leap = (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
        if (t.mday != 0)
            diy = month_start[mon] + ((leap && mon >= 2) ? 1 : 0) + longint'(t.mday) - 1;
        else
            diy = longint'(t.yday);
        days  = days_to_jan1(yr) - days_to_jan1(1970) + diy;
        total = days * 86400 + 3600 * longint'(t.hour) + 60 * longint'(t.minute)
                + longint'(t.sec);
        return total[EPOCH_W-1:0];
    endfunction

    // ---------------- result checker ----------------
    always @(posedge aclk) begin
        logic [EPOCH_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_epochs.size() == 0) begin
                $error("epoch_seconds: unexpected transaction, got %0d",
                       $signed(m_tdata[EPOCH_W-1:0]));
                mismatch_cnt++;
            end else begin
                want = expected_epochs.pop_front();
                if (m_tdata[EPOCH_W-1:0] !== want) begin
                    $error("epoch_seconds: expected %0d, got %0d",
                           $signed(want), $signed(m_tdata[EPOCH_W-1:0]));
                    mismatch_cnt++;
                end
            end
        end
    end

    // ---------------- result sink ----------------
    initial begin : result_sink
        int n;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold_req > 0) begin
                n = sink_hold_req;
                sink_hold_req = 0;
                m_tready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else if (sink_stall_en && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 8);
                m_tready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic send_stamp(stamp_t t);
        int n;
        t.pad = '0;
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 8);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'({$urandom, $urandom});
            repeat (n - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        do @(posedge aclk); while (!s_tready);
        expected_epochs.push_back(epoch_of(t));
    endtask

    task automatic send_fields(int yrs, int mon, int md, int yd, int hr, int mi, int sc);
        stamp_t t;
        t = '0;
        t.years  = YEARS_W'(yrs);
        t.month  = MONTH_W'(mon);
        t.mday   = MDAY_W'(md);
        t.yday   = YDAY_W'(yd);
        t.hour   = HOUR_W'(hr);
        t.minute = MIN_W'(mi);
        t.sec    = SEC_W'(sc);
        send_stamp(t);
    endtask

    task automatic wait_for_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_epochs.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT) @(posedge aclk);
    endtask

    function automatic stamp_t random_stamp();
        stamp_t t;
        t = '0;
        t.years  = YEARS_W'($urandom_range(0, 1023));
        t.month  = MONTH_W'(($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 11));
        case ($urandom_range(0, 9))
            0, 1:    t.mday = '0;
            2:       t.mday = MDAY_W'($urandom);
            default: t.mday = MDAY_W'($urandom_range(1, 28));
        endcase
        t.yday   = YDAY_W'(($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 365));
        t.hour   = HOUR_W'(($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 23));
        t.minute = MIN_W'(($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 59));
        t.sec    = SEC_W'(($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 60));
        return t;
    endfunction

    task automatic test_directed_cases();
        send_fields(70, 0, 1, 0, 0, 0, 0);          // epoch itself
        send_fields(69, 11, 31, 0, 23, 59, 59);     // one second before epoch
        send_fields(0, 0, 1, 0, 0, 0, 0);           // 1900, century not leap
        send_fields(0, 2, 1, 0, 0, 0, 0);
        send_fields(100, 1, 29, 0, 12, 0, 0);       // 2000, leap by 400 rule
        send_fields(100, 2, 1, 0, 0, 0, 0);
        send_fields(200, 2, 1, 0, 0, 0, 0);         // 2100, not leap
        send_fields(104, 2, 1, 0, 0, 0, 0);         // 2004, leap by 4 rule
        send_fields(1023, 11, 31, 0, 23, 59, 60);   // top year, leap second
        send_fields(70, 12, 1, 0, 0, 0, 0);         // month folds up one year
        send_fields(70, 1023, 1, 0, 0, 0, 0);       // largest month
        send_fields(70, -1, 1, 0, 0, 0, 0);         // month borrows one year
        send_fields(70, -12, 1, 0, 0, 0, 0);
        send_fields(0, -1024, 31, 0, 0, 0, 0);      // smallest month, earliest folded year
        send_fields(0, -1024, 0, 0, 0, 0, 0);
        send_fields(70, 5, 0, 511, 0, 0, 0);        // day of year used, month ignored
        send_fields(70, -5, 0, 100, 1, 2, 3);
        send_fields(99, 0, 0, 365, 0, 0, 0);
        send_fields(70, 1, 31, 0, 0, 0, 0);         // day past end of month
        send_fields(1023, 1023, 31, 511, 31, 63, 63);
        send_fields(1023, 0, 0, 511, 31, 63, 63);
        send_fields(512, 682, 16, 170, 16, 42, 21);
        send_fields(511, 341, 15, 341, 15, 21, 42);
    endtask

    task automatic test_random_stamps(int count);
        repeat (count) send_stamp(random_stamp());
    endtask

    task automatic test_output_hold_off();
        wait_for_drain();
        sink_hold_req = 200;
        repeat (40) send_stamp(random_stamp());
    endtask

    task automatic test_input_pause();
        repeat (20) send_stamp(random_stamp());
        wait_for_drain();
        repeat (20) send_stamp(random_stamp());
    endtask

    task automatic test_full_rate();
        src_idle_en   = 1'b0;
        sink_stall_en = 1'b0;
        test_random_stamps(130);
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        src_idle_en   = 1'b1;
        sink_stall_en = 1'b1;
        test_random_stamps(220);
        test_output_hold_off();
        test_input_pause();
        test_random_stamps(220);
        test_full_rate();

        wait_for_drain();
        if (expected_epochs.size() != 0) begin
            $error("epoch_seconds: %0d transactions never arrived", expected_epochs.size());
            mismatch_cnt++;
        end
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/cte_pkg.sv
hw/rtl/cte_front.sv
hw/rtl/cte_queue.sv
hw/rtl/cte_back.sv
hw/rtl/calendar_to_epoch_seconds.sv
bench/tb_calendar_to_epoch_seconds.sv
